// ===== hdl/dlts_pkg.sv =====
// dlts_pkg: shared types and constants of the delta list task scheduler
// holds request/result structs, cell entry and carry types, request and status codes
// no dependencies
`timescale 1ns / 1ps

package dlts_pkg;

	localparam int MAX_TASKS = 16;
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);

	// request type codes
	localparam logic [1:0] REQ_TICK     = 2'd0;
	localparam logic [1:0] REQ_ADD      = 2'd1;
	localparam logic [1:0] REQ_DISPATCH = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_ZERO_PER  = 2'd2;
	localparam logic [1:0] ST_NONE      = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  task_id;
		logic [31:0] start_delay;
		logic [31:0] repeat_period;
	} req_t;

	typedef struct packed {
		logic        dispatched;
		logic [7:0]  dispatched_task;
		logic [1:0]  status;
	} rsp_t;

	// one queue entry held by a cell
	typedef struct packed {
		logic [7:0]  task_id;
		logic [31:0] delta;
		logic [31:0] period;
	} entry_t;

	// item travelling along the chain: seeking its slot, or a displaced entry being pushed
	typedef struct packed {
		logic        vld;
		logic        push;
		logic [7:0]  task_id;
		logic [31:0] delta;
		logic [31:0] period;
	} carry_t;

	// per-cell control from the top level
	typedef struct packed {
		logic occupied;
		logic shift;
		logic tick;
	} cell_ctl_t;

endpackage

// ===== hdl/dlts_cell.sv =====
// dlts_cell: one slot of the delta list, with the carry stage that visits it
// depends on dlts_pkg
`timescale 1ns / 1ps

module dlts_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  dlts_pkg::cell_ctl_t ctl,
	input  dlts_pkg::entry_t   right_entry,
	input  dlts_pkg::carry_t   car_in,
	output dlts_pkg::entry_t   entry,
	output dlts_pkg::carry_t   car_out,
	output logic               stored
);

	dlts_pkg::entry_t ent_q, ent_d;
	dlts_pkg::carry_t car_q;
	logic [32:0]      diff;
	logic             less;

	assign entry = ent_q;
	assign diff  = {1'b0, car_q.delta} - {1'b0, ent_q.delta};
	assign less  = diff[32];

	always_comb begin
		ent_d   = ent_q;
		car_out = '0;
		stored  = 1'b0;
		if (ctl.shift) begin
			ent_d = right_entry;
		end else if (car_q.vld) begin
			if (!ctl.occupied) begin
				// end of the list: item lands here
				ent_d  = '{task_id: car_q.task_id, delta: car_q.delta, period: car_q.period};
				stored = 1'b1;
			end else if (car_q.push) begin
				ent_d   = '{task_id: car_q.task_id, delta: car_q.delta, period: car_q.period};
				car_out = '{vld: 1'b1, push: 1'b1, task_id: ent_q.task_id,
					delta: ent_q.delta, period: ent_q.period};
			end else if (!less) begin
				// ties go behind: keep walking with the remaining delay
				car_out       = car_q;
				car_out.delta = diff[31:0];
			end else begin
				ent_d   = '{task_id: car_q.task_id, delta: car_q.delta, period: car_q.period};
				car_out = '{vld: 1'b1, push: 1'b1, task_id: ent_q.task_id,
					delta: ent_q.delta - car_q.delta, period: ent_q.period};
			end
		end else if (ctl.tick) begin
			ent_d.delta = ent_q.delta - 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_q <= '0;
		end else begin
			car_q <= car_in;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

endmodule

// ===== hdl/delta_list_task_scheduler.sv =====
// delta_list_task_scheduler: periodic task scheduler as a chain of delta list cells
// depends on dlts_pkg and dlts_cell
`timescale 1ns / 1ps

// usage
// - an item (request) is taken at a rising edge with start high and busy low
// - each item gives exactly one result, shown on result for one cycle with done high;
//   the receiver cannot stall, so it must take the result in that cycle
// - tick, rejected add, dispatch with no ready head and the unused code: result in the
//   cycle after the item, busy stays low, so one such item can follow in every cycle
// - accepted add and successful dispatch: the item enters cell 0 and moves one cell
//   per cycle along the chain, past or pushing each occupied entry, until it lands;
//   the result is registered from the landing, busy is high meanwhile
// - a dispatch pops the head by shifting every cell left at the same edge that takes
//   the item, then reinserts the task with delay equal to its period
// - reset clears the entry count, the ready flag and all carries; entry storage
//   itself is not cleared, unused cells are never read
module delta_list_task_scheduler (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  dlts_pkg::req_t   request,
	output logic             busy,
	output logic             done,
	output dlts_pkg::rsp_t   result
);

	localparam int N = dlts_pkg::MAX_TASKS;

	dlts_pkg::entry_t    ent     [N];
	dlts_pkg::carry_t    car_in  [N];
	dlts_pkg::carry_t    car_out [N];
	dlts_pkg::cell_ctl_t ctl     [N];
	logic [N-1:0]        stored;

	logic [dlts_pkg::CNT_W-1:0] count_q;
	logic                       head_ready_q;
	logic                       active_q;    // an item is walking the chain
	logic                       disp_q;      // walking item came from a dispatch
	logic [7:0]                 disp_task_q;
	logic                       done_q;
	dlts_pkg::rsp_t             result_q;

	// decode of the accepted item
	logic             acc;
	logic             chain_done;
	logic             shift_now;
	logic             tick_dec;
	logic             set_ready;
	logic             imm;           // result due next cycle
	dlts_pkg::rsp_t   imm_rsp;
	dlts_pkg::carry_t inject;
	logic             cnt_nz;
	logic             full;

	assign acc        = start & ~active_q;
	assign chain_done = |stored;
	assign cnt_nz     = (count_q != '0);
	assign full       = (count_q == dlts_pkg::CNT_W'(N));

	always_comb begin
		shift_now = 1'b0;
		tick_dec  = 1'b0;
		set_ready = 1'b0;
		imm       = 1'b0;
		imm_rsp   = '{dispatched: 1'b0, dispatched_task: 8'd0, status: dlts_pkg::ST_OK};
		inject    = '0;
		if (acc) begin
			case (request.req_type)
				dlts_pkg::REQ_TICK: begin
					imm = 1'b1;
					if (cnt_nz && !head_ready_q) begin
						// zero delta marks the head ready, otherwise age it
						if (ent[0].delta == 32'd0) begin
							set_ready = 1'b1;
						end else begin
							tick_dec = 1'b1;
						end
					end
				end
				dlts_pkg::REQ_ADD: begin
					if (full) begin
						imm            = 1'b1;
						imm_rsp.status = dlts_pkg::ST_FULL;
					end else if (request.repeat_period == 32'd0) begin
						imm            = 1'b1;
						imm_rsp.status = dlts_pkg::ST_ZERO_PER;
					end else begin
						inject = '{vld: 1'b1, push: 1'b0, task_id: request.task_id,
							delta: request.start_delay, period: request.repeat_period};
					end
				end
				dlts_pkg::REQ_DISPATCH: begin
					if (cnt_nz && head_ready_q) begin
						// pop the head and send it back in with its period as delay
						shift_now = 1'b1;
						inject    = '{vld: 1'b1, push: 1'b0, task_id: ent[0].task_id,
							delta: ent[0].period, period: ent[0].period};
					end else begin
						imm            = 1'b1;
						imm_rsp.status = dlts_pkg::ST_NONE;
					end
				end
				default: begin
					imm = 1'b1;
				end
			endcase
		end
	end

	// chain of cells
	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_cell
			assign ctl[k].occupied = (dlts_pkg::CNT_W'(k) < count_q);
			assign ctl[k].shift    = shift_now;
			if (k == 0) begin : g_head
				assign ctl[k].tick = tick_dec;
				assign car_in[k]   = inject;
			end else begin : g_body
				assign ctl[k].tick = 1'b0;
				assign car_in[k]   = car_out[k-1];
			end

			if (k == N - 1) begin : g_last
				dlts_cell u_cell (
					.clk         (clk),
					.arst_n      (arst_n),
					.ctl         (ctl[k]),
					.right_entry (ent[k]),
					.car_in      (car_in[k]),
					.entry       (ent[k]),
					.car_out     (car_out[k]),
					.stored      (stored[k])
				);
			end else begin : g_mid
				dlts_cell u_cell (
					.clk         (clk),
					.arst_n      (arst_n),
					.ctl         (ctl[k]),
					.right_entry (ent[k+1]),
					.car_in      (car_in[k]),
					.entry       (ent[k]),
					.car_out     (car_out[k]),
					.stored      (stored[k])
				);
			end
		end
	endgenerate

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			head_ready_q <= 1'b0;
			active_q     <= 1'b0;
			disp_q       <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= imm | chain_done;
			if (chain_done) begin
				count_q  <= count_q + dlts_pkg::CNT_W'(1);
				active_q <= 1'b0;
			end else if (inject.vld) begin
				active_q <= 1'b1;
				disp_q   <= shift_now;
				if (shift_now) begin
					count_q <= count_q - dlts_pkg::CNT_W'(1);
				end
			end
			if (shift_now) begin
				head_ready_q <= 1'b0;
			end else if (set_ready) begin
				head_ready_q <= 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (shift_now) begin
			disp_task_q <= ent[0].task_id;
		end
		if (chain_done) begin
			result_q <= '{dispatched: disp_q,
				dispatched_task: disp_q ? disp_task_q : 8'd0,
				status: dlts_pkg::ST_OK};
		end else if (imm) begin
			result_q <= imm_rsp;
		end
	end

	assign busy   = active_q;
	assign done   = done_q;
	assign result = result_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dlts_pkg::CNT_W'(N))
		else $error("entry count beyond capacity");

	a_one_landing: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(stored))
		else $error("more than one cell took the item");

	a_land_when_active: assert property (@(posedge clk) disable iff (!arst_n)
		chain_done |-> active_q)
		else $error("item landed with no walk in progress");

	a_ready_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		head_ready_q |-> cnt_nz)
		else $error("head ready on an empty queue");

	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		inject.vld |=> busy && !done)
		else $error("walk started without busy");

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for the delta list task scheduler
// tracks the timer queue in a scoreboard class and checks every result item against it
// depends on dlts_pkg and delta_list_task_scheduler
`timescale 1ns / 1ps

module testbench;

	// request code the block treats as a no-op
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// generous bound on the whole run, in clock cycles
	localparam int CYCLE_LIMIT = 500000;
	// items per random phase
	localparam int PHASE_ITEMS = 400;

	// idle styles of the sender
	typedef enum int {
		IDLE_RANDOM,
		IDLE_NONE,
		IDLE_MIXED
	} idle_style_t;

	// shadow copy of the timer queue, plus the results still owed by the block
	class task_queue_tracker;
		logic [7:0]      slot_task   [dlts_pkg::MAX_TASKS];
		logic [31:0]     slot_delta  [dlts_pkg::MAX_TASKS];
		logic [31:0]     slot_period [dlts_pkg::MAX_TASKS];
		logic            head_is_ready;
		int              used_slots;
		dlts_pkg::rsp_t  owed_results[$];
		int              errors;

		function new();
			head_is_ready = 1'b0;
			used_slots    = 0;
			errors        = 0;
		endfunction

		// walk past every entry whose running total is no greater than the delay,
		// so equal expiries queue behind the ones already there
		function logic [1:0] insert_task(logic [7:0] id, logic [31:0] delay,
				logic [31:0] period);
			int pos;
			int k;
			if (used_slots >= dlts_pkg::MAX_TASKS)
				return dlts_pkg::ST_FULL;
			if (period == '0)
				return dlts_pkg::ST_ZERO_PER;
			pos = 0;
			while (pos < used_slots && delay >= slot_delta[pos]) begin
				delay -= slot_delta[pos];
				pos++;
			end
			for (k = used_slots; k > pos; k--) begin
				slot_task[k]   = slot_task[k - 1];
				slot_delta[k]  = slot_delta[k - 1];
				slot_period[k] = slot_period[k - 1];
			end
			// successor now counts from the new entry
			if (pos < used_slots)
				slot_delta[pos + 1] -= delay;
			slot_task[pos]   = id;
			slot_delta[pos]  = delay;
			slot_period[pos] = period;
			used_slots++;
			return dlts_pkg::ST_OK;
		endfunction

		// called for every accepted request item
		function void note_request(dlts_pkg::req_t r);
			dlts_pkg::rsp_t exp_rsp;
			logic [7:0]     popped_task;
			logic [31:0]    popped_period;
			int             k;
			exp_rsp = '0;
			case (r.req_type)
				dlts_pkg::REQ_TICK: begin
					if (used_slots > 0 && !head_is_ready) begin
						if (slot_delta[0] == '0)
							head_is_ready = 1'b1;
						else
							slot_delta[0]--;
					end
				end
				dlts_pkg::REQ_ADD: begin
					exp_rsp.status = insert_task(r.task_id, r.start_delay, r.repeat_period);
				end
				dlts_pkg::REQ_DISPATCH: begin
					if (used_slots > 0 && head_is_ready) begin
						popped_task   = slot_task[0];
						popped_period = slot_period[0];
						for (k = 0; k + 1 < used_slots; k++) begin
							slot_task[k]   = slot_task[k + 1];
							slot_delta[k]  = slot_delta[k + 1];
							slot_period[k] = slot_period[k + 1];
						end
						used_slots--;
						head_is_ready = 1'b0;
						// a slot was just freed and the period is nonzero, so this lands
						void'(insert_task(popped_task, popped_period, popped_period));
						exp_rsp.dispatched      = 1'b1;
						exp_rsp.dispatched_task = popped_task;
					end else begin
						exp_rsp.status = dlts_pkg::ST_NONE;
					end
				end
				default: begin
				end
			endcase
			owed_results.push_back(exp_rsp);
		endfunction

		// called for every result item the block puts out
		function void check_result(dlts_pkg::rsp_t got);
			dlts_pkg::rsp_t exp_rsp;
			if (owed_results.size() == 0) begin
				$error("result with no request outstanding: %p", got);
				errors++;
				return;
			end
			exp_rsp = owed_results.pop_front();
			if (got.dispatched !== exp_rsp.dispatched) begin
				$error("dispatched: expected %0d, got %0d", exp_rsp.dispatched,
					got.dispatched);
				errors++;
			end
			if (got.dispatched_task !== exp_rsp.dispatched_task) begin
				$error("dispatched_task: expected %0d, got %0d",
					exp_rsp.dispatched_task, got.dispatched_task);
				errors++;
			end
			if (got.status !== exp_rsp.status) begin
				$error("status: expected %0d, got %0d", exp_rsp.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n;
	logic           start;
	dlts_pkg::req_t request;
	logic           busy;
	logic           done;
	dlts_pkg::rsp_t result;
	int             cycle_count = 0;

	task_queue_tracker tracker;

	delta_list_task_scheduler i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog: a hung handshake or a lost result ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: the block holds a result for one cycle only, take it at that edge
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			tracker.check_result(result);
	end

	function automatic dlts_pkg::req_t make_req(logic [1:0] kind, logic [7:0] id,
			logic [31:0] delay, logic [31:0] period);
		dlts_pkg::req_t r;
		r.req_type      = kind;
		r.task_id       = id;
		r.start_delay   = delay;
		r.repeat_period = period;
		return r;
	endfunction

	function automatic int draw_gap(idle_style_t style);
		case (style)
			IDLE_NONE:  return 0;
			IDLE_MIXED: return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 14);
			default:    return $urandom_range(0, 14);
		endcase
	endfunction

	// entered and left at a falling edge; start is written at most once per step
	task automatic send_item(dlts_pkg::req_t r, int gap);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start   = 1'b1;
		request = r;
		// the item goes in at the first rising edge with busy low
		do
			@(posedge clk);
		while (busy !== 1'b0);
		tracker.note_request(r);
		@(negedge clk);
	endtask

	// sender holds off until the block owes nothing
	task automatic drain_results();
		start = 1'b0;
		while (tracker.owed_results.size() != 0)
			@(negedge clk);
	endtask

	// mostly ticks and dispatches so tasks keep expiring; adds use short delays
	// and periods, with the odd full-range value and the odd zero period
	task automatic run_random_phase(int count, idle_style_t style);
		dlts_pkg::req_t r;
		int             pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			r = make_req(dlts_pkg::REQ_TICK, 8'($urandom_range(0, 255)), $urandom, $urandom);
			if (pick < 45) begin
				r.req_type = dlts_pkg::REQ_TICK;
			end else if (pick < 85) begin
				r.req_type = dlts_pkg::REQ_DISPATCH;
			end else if (pick < 95) begin
				r.req_type = dlts_pkg::REQ_ADD;
				if ($urandom_range(0, 11) != 0)
					r.start_delay = $urandom_range(0, 6);
				case ($urandom_range(0, 15))
					0:       r.repeat_period = '0;
					1:       r.repeat_period = $urandom;
					default: r.repeat_period = $urandom_range(1, 6);
				endcase
			end else begin
				r.req_type = REQ_UNUSED;
			end
			send_item(r, draw_gap(style));
		end
	endtask

	initial begin
		tracker = new();
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty queue cases, unused code, zero period
		send_item(make_req(dlts_pkg::REQ_DISPATCH, 8'h00, 32'h0, 32'h0),
			draw_gap(IDLE_RANDOM));
		send_item(make_req(dlts_pkg::REQ_TICK, 8'hff, 32'hffff_ffff, 32'hffff_ffff), 0);
		send_item(make_req(REQ_UNUSED, 8'h5a, 32'h1234_5678, 32'h8765_4321), 0);
		send_item(make_req(dlts_pkg::REQ_ADD, 8'hff, 32'h0, 32'h0), draw_gap(IDLE_RANDOM));
		// adds: equal expiry goes behind, earlier expiry shortens its successor,
		// extreme delay and period sit at the back
		send_item(make_req(dlts_pkg::REQ_ADD, 8'h01, 32'd3, 32'd2), 0);
		send_item(make_req(dlts_pkg::REQ_ADD, 8'h02, 32'd3, 32'd5), draw_gap(IDLE_RANDOM));
		send_item(make_req(dlts_pkg::REQ_ADD, 8'h03, 32'd1, 32'd1), 0);
		send_item(make_req(dlts_pkg::REQ_ADD, 8'h04, 32'hffff_ffff, 32'hffff_ffff), 0);
		send_item(make_req(dlts_pkg::REQ_ADD, 8'h00, 32'd0, 32'd3), draw_gap(IDLE_RANDOM));
		// head not ready yet
		send_item(make_req(dlts_pkg::REQ_DISPATCH, 8'h00, 32'h0, 32'h0), 0);
		// zero head delta makes it ready, a further tick leaves it alone
		send_item(make_req(dlts_pkg::REQ_TICK, 8'h00, 32'h0, 32'h0), 0);
		send_item(make_req(dlts_pkg::REQ_TICK, 8'h00, 32'h0, 32'h0), draw_gap(IDLE_RANDOM));
		// pop and reinsert, walking past a run of entries
		send_item(make_req(dlts_pkg::REQ_DISPATCH, 8'h00, 32'h0, 32'h0), 0);
		send_item(make_req(dlts_pkg::REQ_TICK, 8'h00, 32'h0, 32'h0), 0);
		send_item(make_req(dlts_pkg::REQ_TICK, 8'h00, 32'h0, 32'h0), 0);
		send_item(make_req(dlts_pkg::REQ_DISPATCH, 8'h00, 32'h0, 32'h0),
			draw_gap(IDLE_RANDOM));
		send_item(make_req(dlts_pkg::REQ_DISPATCH, 8'h00, 32'h0, 32'h0), 0);
		drain_results();

		// random phases, the sender waits for the block to empty between them
		run_random_phase(PHASE_ITEMS, IDLE_RANDOM);
		drain_results();
		run_random_phase(PHASE_ITEMS, IDLE_NONE);
		drain_results();
		run_random_phase(PHASE_ITEMS, IDLE_MIXED);
		drain_results();
		run_random_phase(PHASE_ITEMS, IDLE_RANDOM);
		drain_results();

		// directed: fill whatever room is left, then a full queue rejects even a
		// zero period add, since fullness is checked first
		while (tracker.used_slots < dlts_pkg::MAX_TASKS)
			send_item(make_req(dlts_pkg::REQ_ADD, 8'($urandom_range(0, 255)),
				$urandom_range(0, 6), $urandom_range(1, 6)), draw_gap(IDLE_MIXED));
		send_item(make_req(dlts_pkg::REQ_ADD, 8'haa, 32'd2, 32'd4), 0);
		send_item(make_req(dlts_pkg::REQ_ADD, 8'h55, 32'd2, 32'h0), 0);

		drain_results();
		// allow for anything the block might still emit
		repeat (dlts_pkg::MAX_TASKS + 4) @(negedge clk);

		if (tracker.errors == 0 && tracker.owed_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			if (tracker.owed_results.size() != 0)
				$error("%0d results never arrived", tracker.owed_results.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
